// ----- rtl/sha_pkg.sv -----
package sha_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_part0;
        logic [63:0] digest_part1;
        logic [63:0] digest_part2;
        logic [63:0] digest_part3;
        logic        length_overflow;
    } t_out_item;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // block handed from front to back
    typedef struct packed {
        logic [511:0] block;
        logic         last;
        logic         ovf;
    } t_blk;

    typedef logic [31:0] t_word;

    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

// ----- rtl/sha_front.sv -----
module sha_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sha_pkg::t_in_item i_item,
    output logic             o_full,
    output logic             o_blk_valid,
    output sha_pkg::t_blk    o_blk,
    input  logic             i_blk_ready
);
    typedef enum logic [1:0] {S_FILL, S_PAD2, S_HOLD} t_state;

    t_state        r_state;
    logic [511:0]  r_buf;
    logic [5:0]    r_fill;
    logic [63:0]   r_bits;
    logic          r_ovf;
    logic          r_bvalid;
    sha_pkg::t_blk r_blk;

    logic          accept;
    logic [511:0]  padded;
    logic [511:0]  with80;
    logic [6:0]    fill_p1;

    // accept only in S_FILL, with the out register free or being drained
    assign o_full      = (r_state != S_FILL) || (r_bvalid && !i_blk_ready);
    assign accept      = i_push && !o_full;
    assign o_blk_valid = r_bvalid;
    assign o_blk       = r_blk;
    assign fill_p1     = {1'b0, r_fill} + 7'd1;

    always_comb begin
        with80 = r_buf;
        for (int i = 0; i < 64; i++) begin
            if (i[5:0] == r_fill) with80[511-8*i -: 8] = 8'h80;
            else if (i[5:0] > r_fill) with80[511-8*i -: 8] = 8'h00;
        end
        padded = with80;
        padded[63:0] = r_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FILL;
            r_fill   <= '0;
            r_bits   <= '0;
            r_ovf    <= 1'b0;
            r_bvalid <= 1'b0;
        end else begin
            if (r_bvalid && i_blk_ready) r_bvalid <= 1'b0;
            case (r_state)
                S_FILL: begin
                    if (accept && i_item.kind == sha_pkg::KIND_APPEND) begin
                        if (r_bits > 64'hFFFF_FFFF_FFFF_FFF7) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_bits <= r_bits + 64'd8;
                            r_buf[511-8*r_fill -: 8] <= i_item.data_byte;
                            r_fill <= r_fill + 6'd1;
                            if (r_fill == 6'd63) begin
                                r_blk.block <= {r_buf[511:8], i_item.data_byte};
                                r_blk.last  <= 1'b0;
                                r_blk.ovf   <= 1'b0;
                                r_bvalid    <= 1'b1;
                            end
                        end
                    end else if (accept) begin
                        r_bvalid <= 1'b1;
                        if (fill_p1 > 7'd56) begin
                            r_blk.block <= with80;
                            r_blk.last  <= 1'b0;
                            r_blk.ovf   <= 1'b0;
                            r_buf       <= '0;
                            r_state     <= S_PAD2;
                        end else begin
                            r_blk.block <= padded;
                            r_blk.last  <= 1'b1;
                            r_blk.ovf   <= r_ovf;
                            r_fill <= '0;
                            r_bits <= '0;
                            r_ovf  <= 1'b0;
                        end
                    end
                end
                S_PAD2: begin
                    if (!r_bvalid || i_blk_ready) begin
                        r_bvalid    <= 1'b1;
                        r_blk.block <= {448'b0, r_bits};
                        r_blk.last  <= 1'b1;
                        r_blk.ovf   <= r_ovf;
                        r_fill  <= '0;
                        r_bits  <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_FILL;
                    end
                end
                default: r_state <= S_FILL;
            endcase
        end
    end
endmodule

// ----- rtl/sha_core.sv -----
module sha_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_blk_valid,
    input  sha_pkg::t_blk     i_blk,
    output logic              o_blk_ready,
    output logic              o_empty,
    output sha_pkg::t_out_item o_item,
    input  logic              i_pop
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_ADD} t_state;

    t_state       r_state;
    logic [511:0] r_w;      // 16-word schedule window, w[t] on top
    logic [255:0] r_h;
    logic [255:0] r_v;
    logic [5:0]   r_rnd;
    logic         r_last;
    logic         r_ovf;
    logic         r_ovalid;
    sha_pkg::t_out_item r_out;

    sha_pkg::t_word a, b, c, d, e, f, g, h, t1, t2, wt, s0, s1, wnew;

    assign o_blk_ready = (r_state == S_IDLE) && !(r_ovalid && !i_pop);
    assign o_empty     = !r_ovalid;
    assign o_item      = r_out;

    always_comb begin
        {a, b, c, d, e, f, g, h} = r_v;
        wt = r_w[511:480];
        t1 = h + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
               + ((e & f) ^ (~e & g)) + sha_pkg::round_k(r_rnd) + wt;
        t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
        s0 = sha_pkg::rotr(r_w[479:448], 7) ^ sha_pkg::rotr(r_w[479:448], 18)
               ^ (r_w[479:448] >> 3);
        s1 = sha_pkg::rotr(r_w[63:32], 17) ^ sha_pkg::rotr(r_w[63:32], 19)
               ^ (r_w[63:32] >> 10);
        wnew = wt + s0 + r_w[223:192] + s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_h      <= sha_pkg::H_INIT;
            r_ovalid <= 1'b0;
            r_rnd    <= '0;
        end else begin
            if (r_ovalid && i_pop) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_blk_valid && o_blk_ready) begin
                        r_w     <= i_blk.block;
                        r_v     <= r_h;
                        r_last  <= i_blk.last;
                        r_ovf   <= i_blk.ovf;
                        r_rnd   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_v   <= {t1 + t2, a, b, c, d + t1, e, f, g};
                    r_w   <= {r_w[479:0], wnew};
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        if (r_last) r_h[255-32*i -: 32] <= sha_pkg::H_INIT[255-32*i -: 32];
                        else r_h[255-32*i -: 32] <= r_h[255-32*i -: 32] + r_v[255-32*i -: 32];
                    end
                    if (r_last) begin
                        for (int i = 0; i < 4; i++) begin
                            r_out[256-64*i -: 32] <= r_h[255-64*i -: 32] + r_v[255-64*i -: 32];
                            r_out[224-64*i -: 32] <= r_h[223-64*i -: 32] + r_v[223-64*i -: 32];
                        end
                        r_out.length_overflow <= r_ovf;
                        r_ovalid <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/sha256_stream_hasher.sv -----
// Streaming SHA-256 hasher.
// Input queue: push an item {kind, data_byte} while o_full is low. kind 0
// appends a byte, kind 1 finishes the message. Result queue: while o_empty
// is low the digest of the oldest finished message is shown; pop takes it.
// Bytes are taken one per cycle while o_full is low into a 64-byte buffer;
// a full block goes to a one-entry block register feeding the round unit,
// which runs one round per cycle: per block it loads the block, runs 64
// rounds and adds its working state to the hash. The front keeps filling the
// next block while the round unit works; o_full rises while a block waits
// in the block register, and while the second padded block is made. Finish
// produces one or two padded blocks. A stalled result holds the round unit
// idle and, through the block register, eventually the input.
// Reset (synchronous, active low) empties both queues and restarts at the
// initial hash with an empty message.
module sha256_stream_hasher (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sha_pkg::t_in_item  i_in,
    output logic               o_full,
    output logic               o_empty,
    input  logic               i_pop,
    output sha_pkg::t_out_item o_out
);
    logic          blk_valid;
    logic          blk_ready;
    sha_pkg::t_blk blk;

    sha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_item(i_in),
        .o_full(o_full), .o_blk_valid(blk_valid), .o_blk(blk),
        .i_blk_ready(blk_ready));

    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_blk_valid(blk_valid), .i_blk(blk),
        .o_blk_ready(blk_ready), .o_empty(o_empty), .o_item(o_out),
        .i_pop(i_pop));
endmodule

// ----- rtl/sha_checker.sv -----
module sha_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_full,
    input logic               o_empty,
    input logic               i_pop,
    input sha_pkg::t_out_item o_out
);
    // a waiting result stays until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_out)) else $error("result dropped");
    // queues are empty after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> o_empty && !o_full)
        else $error("reset state");
    // a digest cannot follow a pop in the next cycle
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && i_pop |=> o_empty) else $error("back to back digests");
    // a shown result carries known bits
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> !$isunknown(o_out)) else $error("unknown result");
endmodule

bind sha256_stream_hasher sha_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_full(o_full),
    .o_empty(o_empty), .i_pop(i_pop), .o_out(o_out));
